/* rtl/core/necd_pkg.sv */
// Shared types and constants for the NEC IR frame decoder.
package necd_pkg;

  // Nominal durations and tolerance, in microsecond ticks
  localparam logic [15:0] MARGIN       = 16'd150;
  localparam logic [15:0] NOM_LEADER   = 16'd9000;
  localparam logic [15:0] NOM_HALF     = 16'd4500;
  localparam logic [15:0] NOM_QUARTER  = 16'd2250;
  localparam logic [15:0] NOM_BIT_MARK = 16'd562;
  localparam logic [15:0] NOM_BIT_ONE  = 16'd1675;

  // Frame lengths and symbol positions
  localparam logic [5:0] FRAME_NORMAL  = 6'd34;
  localparam logic [5:0] FRAME_REPEAT  = 6'd2;
  localparam logic [5:0] COUNT_MAX     = 6'd63;
  localparam logic [5:0] DATA_LAST_POS = 6'd32;

  // Queue between classifier and frame engine
  localparam int unsigned FIFO_DEPTH = 2;

  // Register byte addresses
  localparam logic [2:0] REG_SHORT_LEADER = 3'd0;

  typedef enum logic [1:0] {
    STATUS_NORMAL = 2'd0,
    STATUS_REPEAT = 2'd1,
    STATUS_REJECT = 2'd2
  } necd_status_e;

  // Classified symbol
  typedef struct packed {
    logic is_leader;
    logic is_repeat;
    logic is_one;
    logic is_zero;
    logic last;
  } necd_sym_t;

  // Strictly within MARGIN of nominal
  function automatic logic near_f(logic [15:0] v, logic [15:0] nom);
    near_f = (v > (nom - MARGIN)) && (v < (nom + MARGIN));
  endfunction

endpackage

/* rtl/core/necd_front.sv */
// Symbol classifier: judges mark and space durations against the NEC nominals.
module necd_front import necd_pkg::*; #(
  parameter int unsigned DURATION_WIDTH = 15
) (
  input  logic [DURATION_WIDTH-1:0] mark_i,
  input  logic [DURATION_WIDTH-1:0] space_i,
  input  logic                      last_i,
  input  logic                      short_leader_i,
  output necd_sym_t                 sym_o
);

  logic [15:0] mark_w;
  logic [15:0] space_w;
  logic        bit_mark;

  assign mark_w   = 16'(mark_i);
  assign space_w  = 16'(space_i);
  assign bit_mark = near_f(mark_w, NOM_BIT_MARK);

  always_comb begin
    if (short_leader_i) begin
      sym_o.is_leader = near_f(mark_w, NOM_HALF) && near_f(space_w, NOM_HALF);
      sym_o.is_repeat = near_f(mark_w, NOM_QUARTER) && near_f(space_w, NOM_QUARTER);
    end else begin
      sym_o.is_leader = near_f(mark_w, NOM_LEADER) && near_f(space_w, NOM_HALF);
      sym_o.is_repeat = near_f(mark_w, NOM_LEADER) && near_f(space_w, NOM_QUARTER);
    end
    sym_o.is_one  = bit_mark && near_f(space_w, NOM_BIT_ONE);
    sym_o.is_zero = bit_mark && near_f(space_w, NOM_BIT_MARK);
    sym_o.last    = last_i;
  end

endmodule

/* rtl/core/necd_fifo.sv */
// Short queue of classified symbols between classifier and frame engine.
module necd_fifo import necd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  necd_sym_t push_data_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output necd_sym_t pop_data_o
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  necd_sym_t        mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(FIFO_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  function automatic logic [PTR_W-1:0] inc_f(logic [PTR_W-1:0] p);
    inc_f = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? inc_f(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? inc_f(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/necd_back.sv */
// Frame engine: counts symbols, gathers data bits and issues one result per frame.
module necd_back import necd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         sym_valid_i,
  input  necd_sym_t    sym_i,
  output logic         sym_pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output necd_status_e out_status_o,
  output logic [15:0]  out_address_o,
  output logic [7:0]   out_command_o
);

  logic [5:0]   count_q, count_d;
  logic [15:0]  addr_q, addr_d;
  logic [15:0]  cmd_q, cmd_d;
  logic         bad_q, bad_d;
  logic         leader_q, leader_d;
  logic         repeat_q, repeat_d;
  logic         out_valid_q, out_valid_d;
  necd_status_e status_q, status_d;
  logic [15:0]  out_addr_q, out_addr_d;
  logic [7:0]   out_cmd_q, out_cmd_d;
  logic [5:0]   pos_m1;
  logic         pop;

  assign pop       = sym_valid_i && (!out_valid_q || out_ready_i);
  assign sym_pop_o = pop;
  assign pos_m1    = count_q - 6'd1;

  always_comb begin
    count_d     = count_q;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    bad_d       = bad_q;
    leader_d    = leader_q;
    repeat_d    = repeat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    out_addr_d  = out_addr_q;
    out_cmd_d   = out_cmd_q;
    if (pop) begin
      if (count_q == '0) begin
        leader_d = sym_i.is_leader;
        repeat_d = sym_i.is_repeat;
      end else if (count_q <= DATA_LAST_POS) begin
        if (!sym_i.is_one && !sym_i.is_zero) begin
          bad_d = 1'b1;
        end
        if (sym_i.is_one) begin
          if (!pos_m1[4]) begin
            addr_d[pos_m1[3:0]] = 1'b1;
          end else begin
            cmd_d[pos_m1[3:0]] = 1'b1;
          end
        end
      end
      if (count_q != COUNT_MAX) begin
        count_d = count_q + 6'd1;
      end
      if (sym_i.last) begin
        out_valid_d = 1'b1;
        status_d    = STATUS_REJECT;
        out_addr_d  = '0;
        out_cmd_d   = '0;
        if (count_d == FRAME_NORMAL) begin
          if (leader_d && !bad_d && ((~cmd_d[15:8]) == cmd_d[7:0])) begin
            status_d   = STATUS_NORMAL;
            out_addr_d = addr_d;
            out_cmd_d  = cmd_d[7:0];
          end
        end else if (count_d == FRAME_REPEAT) begin
          if (repeat_d) begin
            status_d = STATUS_REPEAT;
          end
        end
        count_d  = '0;
        addr_d   = '0;
        cmd_d    = '0;
        bad_d    = 1'b0;
        leader_d = 1'b0;
        repeat_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      addr_q      <= '0;
      cmd_q       <= '0;
      bad_q       <= 1'b0;
      leader_q    <= 1'b0;
      repeat_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      addr_q      <= addr_d;
      cmd_q       <= cmd_d;
      bad_q       <= bad_d;
      leader_q    <= leader_d;
      repeat_q    <= repeat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    out_addr_q <= out_addr_d;
    out_cmd_q  <= out_cmd_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_status_o  = status_q;
  assign out_address_o = out_addr_q;
  assign out_command_o = out_cmd_q;

endmodule

/* rtl/core/nec_ir_frame_decoder.sv */
// NEC IR frame decoder top level: classifier, symbol queue, frame engine, register port.
// Throughput: one symbol per cycle while no result waits to be taken; the frame engine retires one queued
// symbol each cycle unless a stalled result holds it. Result path: queue -> registered result (result reg).
// The two-entry queue lets the input side keep going while a result waits to be taken.
// Reset (rst_ni, async, active low) clears the queue, frame state, result valid and
// short_leader; no clearing pass is needed.
module nec_ir_frame_decoder import necd_pkg::*; #(
  parameter int unsigned DURATION_WIDTH = 15
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input symbols
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: [DW-1:0] mark_duration, [2*DW-1:DW] space_duration, zero padding above
  input  logic [((2 * DURATION_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic                  s_axis_tlast,   // last_symbol
  // Results
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: [15:0] address, [23:16] command
  output logic [23:0]           m_axis_tdata,
  // tuser: [1:0] frame_status
  output logic [1:0]            m_axis_tuser,
  // Register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic         short_leader_q, short_leader_d;
  necd_sym_t    front_sym;
  necd_sym_t    queue_sym;
  logic         queue_full;
  logic         queue_valid;
  logic         queue_pop;
  logic         in_take;
  necd_status_e res_status;
  logic [15:0]  res_address;
  logic [7:0]   res_command;

  // Configuration: single bit register at byte address 0 (only paddr[2] is decoded, so 1 to 3 alias it)
  assign pready = 1'b1;
  always_comb begin
    short_leader_d = short_leader_q;
    if (psel && penable && pwrite && (paddr[2] == REG_SHORT_LEADER[2])) begin
      short_leader_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_leader_q <= 1'b0;
    end else begin
      short_leader_q <= short_leader_d;
    end
  end

  assign prdata = (paddr[2] == REG_SHORT_LEADER[2]) ? {31'd0, short_leader_q} : 32'd0;

  // Front: classify each symbol as it is taken
  necd_front #(
    .DURATION_WIDTH(DURATION_WIDTH)
  ) u_front (
    .mark_i        (s_axis_tdata[DURATION_WIDTH-1:0]),
    .space_i       (s_axis_tdata[2*DURATION_WIDTH-1:DURATION_WIDTH]),
    .last_i        (s_axis_tlast),
    .short_leader_i(short_leader_q),
    .sym_o         (front_sym)
  );

  assign s_axis_tready = !queue_full;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  necd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_take),
    .push_data_i(front_sym),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .valid_o    (queue_valid),
    .pop_data_o (queue_sym)
  );

  // Back: frame state and result register
  necd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sym_valid_i  (queue_valid),
    .sym_i        (queue_sym),
    .sym_pop_o    (queue_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (res_status),
    .out_address_o(res_address),
    .out_command_o(res_command)
  );

  assign m_axis_tdata = {res_command, res_address};
  assign m_axis_tuser = res_status;

  // Only a normal frame carries address and command
  a_zero_unless_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != STATUS_NORMAL)) |-> (m_axis_tdata == 24'd0))
    else $error("non-normal result carries data");

  // Status code three is never issued
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("undefined frame status");

  // A symbol leaves the queue only while one is held
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queue_pop |-> queue_valid)
    else $error("pop from empty queue");

  // Full queue with a stalled output stays full next cycle
  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (queue_full && m_axis_tvalid && !m_axis_tready) |=> queue_full)
    else $error("queue drained while result stalled");

endmodule
